[sv/metx_pkg.sv]
// ---------------------------------------------------------------------------
// metx_pkg: shared types and constants for the mouse event to X10 report block
// Holds the beat payload structs, event codes, register indexes, report bytes
// and the control state encoding.
// ---------------------------------------------------------------------------
package metx_pkg;

    // Input beat: one evdev-style event
    typedef struct packed {
        logic [4:0]         event_type;
        logic [9:0]         event_code;
        logic signed [15:0] event_value;
    } t_evt_in;

    // Output beat: one report byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_rpt_out;

    // Control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEND
    } t_state;

    // Event types and codes
    localparam logic [4:0] EV_KEY_TYPE    = 5'd1;
    localparam logic [4:0] EV_REL_TYPE    = 5'd2;
    localparam logic [9:0] CODE_REL_X     = 10'd0;
    localparam logic [9:0] CODE_REL_Y     = 10'd1;
    localparam logic [9:0] CODE_WHEEL     = 10'd8;
    localparam logic [9:0] CODE_BTN_FIRST = 10'h110;
    localparam logic [9:0] CODE_BTN_LAST  = 10'h116;

    // Register port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS   = 3'd4;

    // Register defaults
    localparam logic [7:0] RST_CELL_WIDTH  = 8'd8;
    localparam logic [7:0] RST_CELL_HEIGHT = 8'd16;
    localparam logic [7:0] RST_SCREEN_COLS = 8'd80;
    localparam logic [7:0] RST_SCREEN_ROWS = 8'd25;

    // Report bytes
    localparam logic [7:0] BYTE_ESC     = 8'h1B;
    localparam logic [7:0] BYTE_LBRACK  = 8'h5B;
    localparam logic [7:0] BYTE_M       = 8'h4D;
    localparam logic [7:0] BYTE_OFFSET  = 8'd32;
    localparam logic [7:0] BYTE_RELEASE = 8'd64;
    localparam logic [7:0] WHEEL_UP     = 8'd4;
    localparam logic [7:0] WHEEL_DOWN   = 8'd5;
    localparam int         REPORT_BYTES = 6;

endpackage

[sv/metx_cell_div.sv]
// ---------------------------------------------------------------------------
// metx_cell_div: bit-serial pixel to cell converter
// Restoring divide of the pixel position by the cell size, one quotient bit
// per cycle, then a clamp of the quotient to the last cell of the screen.
// ---------------------------------------------------------------------------
module metx_cell_div #(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COORD_BITS-1:0] i_pix,
    input  logic [7:0]            i_size,
    input  logic [7:0]            i_limit,
    output logic                  o_done,
    output logic [7:0]            o_cell
);
    import metx_pkg::*;

    localparam int CNT_W = $clog2(COORD_BITS + 1);

    logic [COORD_BITS-1:0] r_quo;
    logic [7:0]            r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [7:0]            size_eff;
    logic [7:0]            limit_eff;
    logic [8:0]            rem_sh;
    logic [9:0]            diff;
    logic                  q_bit;

    // Treat a zero divisor or zero screen size as one
    assign size_eff  = (i_size == 8'd0) ? 8'd1 : i_size;
    assign limit_eff = (i_limit == 8'd0) ? 8'd1 : i_limit;

    // One restoring step: shift in the next dividend bit, trial subtract
    assign rem_sh = {r_rem, r_quo[COORD_BITS-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, size_eff};
    assign q_bit  = ~diff[9];

    // Advance the divide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(COORD_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Dividend shifts out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_pix;
            r_rem <= 8'd0;
        end else if (r_busy) begin
            r_quo <= {r_quo[COORD_BITS-2:0], q_bit};
            r_rem <= q_bit ? diff[7:0] : rem_sh[7:0];
        end
    end

    // Clamp to the last cell
    assign o_done = r_done;
    assign o_cell = (r_quo >= COORD_BITS'(limit_eff)) ? (limit_eff - 8'd1) : r_quo[7:0];

endmodule

[sv/mouse_event_to_x10_report.sv]
// Order: a motion or ignored event is taken while idle; a reporting event runs
// the bit-serial cell divide before the first byte is shown.
// One item at a time: no new event is taken until the cell divide, one bit per
// cycle, and the six output beats, each held by i_ready, are done.
// Reset: synchronous active low; clears the pointer, loads register defaults.
// ---------------------------------------------------------------------------
// mouse_event_to_x10_report: evdev mouse events to X10 terminal reports
// Tracks a saturating pixel pointer and, on button or wheel events with reporting
// enabled, sends ESC [ M, button byte, column byte and row byte, one byte per beat.
// ---------------------------------------------------------------------------
module mouse_event_to_x10_report #(
    parameter int COORD_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  metx_pkg::t_evt_in                    i_data,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output metx_pkg::t_rpt_out                   o_data,
    input  logic                                 i_cfg_we,
    input  logic [metx_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [metx_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import metx_pkg::*;

    localparam int SUM_W = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
    localparam int SH_W  = 8 * REPORT_BYTES;

    // Configuration registers
    logic       r_report_enable;
    logic [7:0] r_cell_width;
    logic [7:0] r_cell_height;
    logic [7:0] r_screen_cols;
    logic [7:0] r_screen_rows;

    // Pointer and control
    logic [COORD_BITS-1:0] r_ptr_x;
    logic [COORD_BITS-1:0] r_ptr_y;
    t_state                r_state;
    t_state                n_state;
    logic [7:0]            r_btn_byte;
    logic [SH_W-1:0]       r_shift;
    logic [2:0]            r_idx;

    logic                  in_fire;
    logic                  out_fire;
    logic                  is_rel;
    logic                  is_key;
    logic                  is_wheel;
    logic                  is_btn;
    logic                  do_report;
    logic [7:0]            btn_num;
    logic [7:0]            btn_byte;
    logic                  move_x;
    logic                  move_y;
    logic [COORD_BITS-1:0] cur_pos;
    logic signed [SUM_W-1:0] sum;
    logic [COORD_BITS-1:0] new_pos;
    logic                  div_done_x;
    logic                  div_done_y;
    logic [7:0]            cell_x;
    logic [7:0]            cell_y;

    assign in_fire  = i_valid && o_ready;
    assign out_fire = o_valid && i_ready;

    // Decode the event
    assign is_rel    = (i_data.event_type == EV_REL_TYPE);
    assign is_key    = (i_data.event_type == EV_KEY_TYPE);
    assign is_wheel  = is_rel && (i_data.event_code == CODE_WHEEL);
    assign is_btn    = is_key && (i_data.event_code >= CODE_BTN_FIRST)
                       && (i_data.event_code <= CODE_BTN_LAST);
    assign move_x    = is_rel && (i_data.event_code == CODE_REL_X);
    assign move_y    = is_rel && (i_data.event_code == CODE_REL_Y);
    assign do_report = r_report_enable && (is_wheel || is_btn);

    // Form the button byte
    assign btn_num = 8'(i_data.event_code - CODE_BTN_FIRST) + 8'd1;
    always_comb begin
        if (is_wheel) begin
            btn_byte = BYTE_OFFSET + ((i_data.event_value > 16'sd0) ? WHEEL_UP : WHEEL_DOWN);
        end else begin
            btn_byte = BYTE_OFFSET + btn_num
                       + ((i_data.event_value == 16'sd0) ? BYTE_RELEASE : 8'd0);
        end
    end

    // Add motion, floor at zero, saturate at full scale
    assign cur_pos = move_x ? r_ptr_x : r_ptr_y;
    assign sum = $signed({{(SUM_W-COORD_BITS){1'b0}}, cur_pos})
               + $signed({{(SUM_W-16){i_data.event_value[15]}}, i_data.event_value});
    always_comb begin
        if (sum[SUM_W-1]) begin
            new_pos = '0;
        end else if (sum[SUM_W-2:COORD_BITS] != '0) begin
            new_pos = '1;
        end else begin
            new_pos = sum[COORD_BITS-1:0];
        end
    end

    // Cell dividers, run side by side
    metx_cell_div #(.COORD_BITS(COORD_BITS)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire && do_report),
        .i_pix   (r_ptr_x),
        .i_size  (r_cell_width),
        .i_limit (r_screen_cols),
        .o_done  (div_done_x),
        .o_cell  (cell_x)
    );

    metx_cell_div #(.COORD_BITS(COORD_BITS)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire && do_report),
        .i_pix   (r_ptr_y),
        .i_size  (r_cell_height),
        .i_limit (r_screen_rows),
        .o_done  (div_done_y),
        .o_cell  (cell_y)
    );

    // Next state and handshake outputs
    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && do_report) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done_x) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                o_valid = 1'b1;
                if (i_ready && (r_idx == 3'(REPORT_BYTES - 1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_enable <= 1'b0;
            r_cell_width    <= RST_CELL_WIDTH;
            r_cell_height   <= RST_CELL_HEIGHT;
            r_screen_cols   <= RST_SCREEN_COLS;
            r_screen_rows   <= RST_SCREEN_ROWS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REPORT_ENABLE: r_report_enable <= i_cfg_data[0];
                CFG_CELL_WIDTH:    r_cell_width    <= i_cfg_data;
                CFG_CELL_HEIGHT:   r_cell_height   <= i_cfg_data;
                CFG_SCREEN_COLS:   r_screen_cols   <= i_cfg_data;
                CFG_SCREEN_ROWS:   r_screen_rows   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Update the pointer on motion beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr_x <= '0;
            r_ptr_y <= '0;
        end else if (in_fire) begin
            if (move_x) begin
                r_ptr_x <= new_pos;
            end
            if (move_y) begin
                r_ptr_y <= new_pos;
            end
        end
    end

    // Load the report and shift it out one byte per beat
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_btn_byte <= btn_byte;
        end
        if (r_state == ST_DIV && div_done_x) begin
            r_shift <= {BYTE_ESC, BYTE_LBRACK, BYTE_M, r_btn_byte,
                        BYTE_OFFSET + cell_x, BYTE_OFFSET + cell_y};
        end else if (out_fire) begin
            r_shift <= {r_shift[SH_W-9:0], 8'd0};
        end
    end

    // Count bytes of the report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
        end else if (r_state == ST_DIV) begin
            r_idx <= 3'd0;
        end else if (out_fire) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    assign o_data.out_byte  = r_shift[SH_W-1:SH_W-8];
    assign o_data.last_byte = (r_idx == 3'(REPORT_BYTES - 1));

    // Checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while a report is in flight");

    a_divs_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done_x == div_done_y)
        else $error("cell dividers out of step");

    a_report_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && do_report) |=> (r_state == ST_DIV))
        else $error("reporting event did not start a divide");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_data.last_byte) |=> (r_state == ST_IDLE))
        else $error("report did not end after the last byte");

endmodule
